### rtl/sat_pkg.sv
// Shared definitions for the sorted alarm table: operation and status codes,
// fixed field widths and the flag bundle returned by the compare unit.
// No dependencies.
`timescale 1ns / 1ps

package sat_pkg;

    localparam int KIND_W     = 3;
    localparam int DEADLINE_W = 32;
    localparam int KEY_W      = 64;
    localparam int STATUS_W   = 2;
    localparam int FOUND_W    = 6;
    localparam int COUNT_W    = 7;

    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIND       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE_ALL = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;

    // Result of comparing one stored entry against the operation's operands.
    typedef struct packed {
        logic dl_gt;   // stored deadline is later than the new one
        logic key_eq;  // stored key equals the operation key
    } cmp_flags_t;

endpackage

### rtl/sat_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sat_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/sat_cmp.sv
// Shared compare unit: deadline ordering and key equality for one entry.
// Depends on sat_pkg.
`timescale 1ns / 1ps

module sat_cmp
    import sat_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic [TIME_BITS-1:0] entry_deadline,
    input  logic [KEY_W-1:0]     entry_key,
    input  logic [TIME_BITS-1:0] op_deadline,
    input  logic [KEY_W-1:0]     op_key,
    output cmp_flags_t           flags
);

    always_comb
    begin
        flags.dl_gt  = entry_deadline > op_deadline;
        flags.key_eq = entry_key == op_key;
    end

endmodule

### rtl/sorted_alarm_table_core.sv
// Top level of the sorted alarm table: sequencer, entry memory and compare unit.
// Depends on sat_pkg, sat_ram and sat_cmp.
`timescale 1ns / 1ps

// Channel  Valid      Stall      Payload
// -------  ---------  ---------  ---------------------------------------------
// in       in_valid   in_stall   kind, deadline, name_key
// out      out_valid  out_stall  status, found_index, removed_count,
//                                entries_held
//
// Clear, unused kinds and an insert into a full table go straight to the result state.
// Other inserts move each held entry with a later deadline up one slot, then write the new one.
// Find and the removes read each held entry once.
// Reset clears the entry count and control state; the entry memory is never cleared.
// The input stalls from the cycle after a transfer until the result is loaded, and a
// finished result waits while the output register still holds an unaccepted one.

module sorted_alarm_table_core
    import sat_pkg::*;
#(
    parameter int ROWS      = 64,
    parameter int TIME_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [KIND_W-1:0]     kind,
    input  logic [DEADLINE_W-1:0] deadline,
    input  logic [KEY_W-1:0]      name_key,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [FOUND_W-1:0]    found_index,
    output logic [COUNT_W-1:0]    removed_count,
    output logic [COUNT_W-1:0]    entries_held
);

    localparam int IDX_W   = $clog2(ROWS);
    localparam int CNT_W   = $clog2(ROWS + 1);
    localparam int ENTRY_W = TIME_BITS + KEY_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_INSERT = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [TIME_BITS-1:0] dl_reg, dl_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     rd_reg, rd_next;
    logic [CNT_W-1:0]     wr_reg, wr_next;
    logic [IDX_W-1:0]     proc_reg, proc_next;
    logic                 pend_reg, pend_next;
    logic                 matched_reg, matched_next;
    logic [IDX_W-1:0]     at_reg, at_next;
    logic [CNT_W-1:0]     removed_reg, removed_next;

    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [FOUND_W-1:0]   res_found_reg, res_found_next;
    logic [COUNT_W-1:0]   res_removed_reg, res_removed_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [FOUND_W-1:0]   found_reg, found_next;
    logic [COUNT_W-1:0]   removed_out_reg, removed_out_next;
    logic [COUNT_W-1:0]   held_reg, held_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    cmp_flags_t           flags;
    logic                 skip;

    // Deadline and key of one alarm share a memory word, deadline on top.
    sat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROWS)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sat_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_cmp (
        .entry_deadline (ram_rdata[ENTRY_W-1:KEY_W]),
        .entry_key      (ram_rdata[KEY_W-1:0]),
        .op_deadline    (dl_reg),
        .op_key         (key_reg),
        .flags          (flags)
    );

    assign in_stall      = state_reg != ST_IDLE;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found_index   = found_reg;
    assign removed_count = removed_out_reg;
    assign entries_held  = held_reg;

    // A match is dropped by remove-all always, and by remove only the first time.
    assign skip = flags.key_eq && ((kind_reg == KIND_REMOVE_ALL) || !matched_reg);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        kind_next        = kind_reg;
        dl_next          = dl_reg;
        key_next         = key_reg;
        pos_next         = pos_reg;
        rd_next          = rd_reg;
        wr_next          = wr_reg;
        proc_next        = proc_reg;
        pend_next        = pend_reg;
        matched_next     = matched_reg;
        at_next          = at_reg;
        removed_next     = removed_reg;
        res_status_next  = res_status_reg;
        res_found_next   = res_found_reg;
        res_removed_next = res_removed_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        found_next       = found_reg;
        removed_out_next = removed_out_reg;
        held_next        = held_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next        = kind;
                    dl_next          = TIME_BITS'(deadline);
                    key_next         = name_key;
                    pos_next         = count_reg[IDX_W-1:0];
                    rd_next          = '0;
                    wr_next          = '0;
                    pend_next        = 1'b0;
                    matched_next     = 1'b0;
                    at_next          = '0;
                    removed_next     = '0;
                    res_status_next  = STATUS_OK;
                    res_found_next   = '0;
                    res_removed_next = '0;
                    case (kind)
                        KIND_CLEAR:
                        begin
                            res_removed_next = COUNT_W'(count_reg);
                            count_next       = '0;
                            state_next       = ST_DONE;
                        end
                        KIND_INSERT:
                        begin
                            if (count_reg == CNT_W'(ROWS))
                            begin
                                res_status_next = STATUS_FULL;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_INSERT;
                            end
                        end
                        KIND_FIND, KIND_REMOVE, KIND_REMOVE_ALL:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_INSERT:
            begin
                // pos_reg is the free slot; the entry below it is examined and
                // moved up while its deadline is later than the new one.
                if (pend_reg && flags.dl_gt)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg;
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - 1'b1;
                    if (pos_reg != IDX_W'(1))
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = pos_reg - 1'b1 - 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
                else if (!pend_reg && pos_reg != '0)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_reg - 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    ram_wdata  = {dl_reg, key_reg};
                    count_next = count_reg + 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                end
            end

            ST_SCAN:
            begin
                // Reads run one entry ahead of the compare; kept entries are
                // copied down to the write pointer, which closes every gap.
                if (rd_reg < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = rd_reg[IDX_W-1:0];
                    proc_next = rd_reg[IDX_W-1:0];
                    rd_next   = rd_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (flags.key_eq && !matched_reg)
                    begin
                        matched_next = 1'b1;
                        at_next      = proc_reg;
                    end
                    if (kind_reg != KIND_FIND)
                    begin
                        if (skip)
                        begin
                            removed_next = removed_reg + 1'b1;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = wr_reg[IDX_W-1:0];
                            ram_wdata = ram_rdata;
                            wr_next   = wr_reg + 1'b1;
                        end
                    end
                end
                else if (rd_reg >= count_reg)
                begin
                    res_status_next = matched_reg ? STATUS_OK : STATUS_NO_MATCH;
                    if (matched_reg && kind_reg != KIND_REMOVE_ALL)
                    begin
                        res_found_next = FOUND_W'(at_reg);
                    end
                    if (kind_reg != KIND_FIND)
                    begin
                        res_removed_next = COUNT_W'(removed_reg);
                        count_next       = wr_reg;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    found_next       = res_found_reg;
                    removed_out_next = res_removed_reg;
                    held_next        = COUNT_W'(count_reg);
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        dl_reg          <= dl_next;
        key_reg         <= key_next;
        pos_reg         <= pos_next;
        rd_reg          <= rd_next;
        wr_reg          <= wr_next;
        proc_reg        <= proc_next;
        matched_reg     <= matched_next;
        at_reg          <= at_next;
        removed_reg     <= removed_next;
        res_status_reg  <= res_status_next;
        res_found_reg   <= res_found_next;
        res_removed_reg <= res_removed_next;
        status_reg      <= status_next;
        found_reg       <= found_next;
        removed_out_reg <= removed_out_next;
        held_reg        <= held_next;
    end

endmodule

### verif/sorted_alarm_table_core_tb.sv
// Self-checking testbench for sorted_alarm_table_core: directed, full-table,
// back-pressure and random operation sequences checked against a behavioral mirror.
// Depends on sat_pkg and the sorted_alarm_table_core RTL.
`timescale 1ns / 1ps

module sorted_alarm_table_core_tb;
    import sat_pkg::*;

    localparam int ROWS      = 64;
    localparam int TIME_BITS = 32;

    // Deadlines are cut to TIME_BITS bits before they are stored.
    localparam logic [DEADLINE_W-1:0] TIME_MASK =
        (TIME_BITS >= DEADLINE_W) ? '1 : DEADLINE_W'((64'd1 << TIME_BITS) - 1);

    // Cycles in a row with no transfer on either channel before the run is abandoned.
    // The limit lies well above the slowest operation and the long receiver hold.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;

    // One result as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found;
        logic [COUNT_W-1:0]  removed;
        logic [COUNT_W-1:0]  held;
    } alarm_reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind = KIND_CLEAR;
    logic [DEADLINE_W-1:0] deadline = '0;
    logic [KEY_W-1:0]      name_key = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [FOUND_W-1:0]    found_index;
    logic [COUNT_W-1:0]    removed_count;
    logic [COUNT_W-1:0]    entries_held;

    // Mirror of the alarm table, kept in the same ascending deadline order.
    logic [DEADLINE_W-1:0] mirror_dl  [ROWS];
    logic [KEY_W-1:0]      mirror_key [ROWS];
    int                    mirror_held = 0;

    // Results still owed by the block, oldest first.
    alarm_reply_t replies_q [$];

    int errors        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;
    int hold_left     = 0;
    bit hold_request  = 1'b0;

    // A handful of keys that recur, so that duplicates and multi-matches are common.
    logic [KEY_W-1:0] key_pool [8] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h2,
                                       64'h8000_0000_0000_0000, 64'h5A5A_A5A5_0F0F_F0F0,
                                       64'h3, 64'h7FFF_FFFF_FFFF_FFFF};

    sorted_alarm_table_core #(
        .ROWS      (ROWS),
        .TIME_BITS (TIME_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .deadline      (deadline),
        .name_key      (name_key),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found_index   (found_index),
        .removed_count (removed_count),
        .entries_held  (entries_held)
    );

    always #1 clk = ~clk;

    // Deletes the mirror entry at the given index and closes the gap behind it.
    function automatic void mirror_drop(int at);
        int j;
        for (j = at; j + 1 < mirror_held; j++) begin
            mirror_dl[j]  = mirror_dl[j + 1];
            mirror_key[j] = mirror_key[j + 1];
        end
        mirror_held--;
    endfunction

    // Applies one operation to the mirror and returns the result the block owes for it.
    function automatic alarm_reply_t alarm_table_apply(logic [KIND_W-1:0] k,
                                                       logic [DEADLINE_W-1:0] dl,
                                                       logic [KEY_W-1:0] key);
        alarm_reply_t r;
        int pos;
        int at;
        int cnt;
        r = '0;
        dl = dl & TIME_MASK;
        case (k)
            KIND_CLEAR: begin
                r.removed = COUNT_W'(mirror_held);
                mirror_held = 0;
            end
            KIND_INSERT: begin
                if (mirror_held >= ROWS) begin
                    r.status = STATUS_FULL;
                end else begin
                    // Walk down from the end; equal deadlines stay ahead of the new entry.
                    pos = mirror_held;
                    while (pos > 0 && mirror_dl[pos - 1] > dl) begin
                        mirror_dl[pos]  = mirror_dl[pos - 1];
                        mirror_key[pos] = mirror_key[pos - 1];
                        pos--;
                    end
                    mirror_dl[pos]  = dl;
                    mirror_key[pos] = key;
                    mirror_held++;
                end
            end
            KIND_FIND, KIND_REMOVE: begin
                at = -1;
                for (pos = 0; pos < mirror_held && at < 0; pos++) begin
                    if (mirror_key[pos] == key) at = pos;
                end
                if (at < 0) begin
                    r.status = STATUS_NO_MATCH;
                end else begin
                    r.found = FOUND_W'(at);
                    if (k == KIND_REMOVE) begin
                        mirror_drop(at);
                        r.removed = COUNT_W'(1);
                    end
                end
            end
            KIND_REMOVE_ALL: begin
                cnt = 0;
                pos = 0;
                while (pos < mirror_held) begin
                    if (mirror_key[pos] == key) begin
                        mirror_drop(pos);
                        cnt++;
                    end else begin
                        pos++;
                    end
                end
                r.removed = COUNT_W'(cnt);
                if (cnt == 0) r.status = STATUS_NO_MATCH;
            end
            default: begin
                // Unused kinds leave the table alone and report only the entry count.
            end
        endcase
        r.held = COUNT_W'(mirror_held);
        return r;
    endfunction

    // Offers one operation after a random gap, waits for the transfer and
    // records the result it must produce.
    task automatic send_op(input logic [KIND_W-1:0] k, input logic [DEADLINE_W-1:0] dl,
                           input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        kind     <= k;
        deadline <= dl;
        name_key <= key;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        replies_q.push_back(alarm_table_apply(k, dl, key));
    endtask

    // Keys are mostly taken from live entries so that lookups tend to hit.
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60 && mirror_held > 0) return mirror_key[$urandom_range(mirror_held - 1)];
        if (sel < 85) return key_pool[$urandom_range(7)];
        return {$urandom, $urandom};
    endfunction

    // A narrow deadline range gives many ties; the rest spans the full field.
    function automatic logic [DEADLINE_W-1:0] pick_deadline();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return DEADLINE_W'($urandom_range(15));
        if (sel < 45) return '0;
        if (sel < 50) return '1 - DEADLINE_W'($urandom_range(1));
        return $urandom;
    endfunction

    // Empty-table corner cases, unused kinds, extreme field values, ties and duplicates.
    task automatic test_directed();
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        key_a = 64'hA5A5_0000_1234_5678;
        key_b = 64'h0000_BEEF_0000_0001;
        send_op(KIND_FIND, '0, '0);
        send_op(KIND_REMOVE, '0, '1);
        send_op(KIND_REMOVE_ALL, '0, key_a);
        send_op(KIND_CLEAR, '1, '1);
        send_op(3'd5, '1, '1);
        send_op(3'd6, '0, '0);
        send_op(3'd7, 32'h5555_AAAA, 64'hAAAA_5555_AAAA_5555);
        send_op(KIND_INSERT, '1, '1);
        send_op(KIND_INSERT, '0, '0);
        send_op(KIND_INSERT, 32'd100, key_a);
        send_op(KIND_INSERT, 32'd100, key_b);
        send_op(KIND_INSERT, 32'd100, key_a);
        send_op(KIND_INSERT, 32'd50, 64'hC);
        send_op(KIND_INSERT, 32'd7, key_a);
        send_op(KIND_FIND, '1, key_a);
        send_op(KIND_FIND, '0, 64'hDEAD);
        send_op(KIND_FIND, '0, '1);
        send_op(KIND_REMOVE, '0, key_a);
        send_op(KIND_REMOVE_ALL, '0, key_a);
        send_op(KIND_REMOVE_ALL, '0, key_a);
        send_op(3'd5, '0, key_b);
        send_op(KIND_CLEAR, '0, '0);
        send_op(KIND_FIND, '0, key_b);
    endtask

    // Fills the table twice: once with one shared key, once with distinct keys.
    task automatic test_full_table();
        logic [KEY_W-1:0] shared;
        int i;
        shared = {$urandom, $urandom};
        for (i = 0; i < ROWS; i++) send_op(KIND_INSERT, DEADLINE_W'($urandom_range(7)), shared);
        send_op(KIND_INSERT, 32'd3, ~shared);
        send_op(3'd6, '0, '0);
        send_op(KIND_FIND, '0, shared);
        send_op(KIND_REMOVE_ALL, '0, shared);
        for (i = 0; i < ROWS; i++) send_op(KIND_INSERT, $urandom, KEY_W'(i));
        send_op(KIND_INSERT, '1, '1);
        send_op(KIND_FIND, '0, mirror_key[ROWS - 1]);
        send_op(KIND_REMOVE, '0, mirror_key[ROWS / 2]);
        send_op(KIND_INSERT, '0, '1);
        send_op(KIND_INSERT, '0, '0);
        send_op(KIND_CLEAR, '0, '0);
    endtask

    // The receiver holds off for a long stretch while operations keep coming,
    // so the output register and the sequencer fill and the input stalls.
    task automatic test_backpressure();
        int i;
        hold_request = 1'b1;
        for (i = 0; i < 24; i++) begin
            if (i % 3 == 0) send_op(KIND_INSERT, pick_deadline(), pick_key());
            else send_op(KIND_FIND, '0, pick_key());
        end
    endtask

    // Mostly well-formed table traffic with random content, plus raw noise.
    task automatic test_random(input int count);
        int n;
        int sel;
        for (n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 50) send_op(KIND_INSERT, pick_deadline(), pick_key());
            else if (sel < 68) send_op(KIND_FIND, $urandom, pick_key());
            else if (sel < 82) send_op(KIND_REMOVE, $urandom, pick_key());
            else if (sel < 88) send_op(KIND_REMOVE_ALL, $urandom, pick_key());
            else if (sel < 89) send_op(KIND_CLEAR, $urandom, {$urandom, $urandom});
            else if (sel < 92) send_op(KIND_W'($urandom_range(5, 7)), $urandom, pick_key());
            else send_op(KIND_W'($urandom_range(7)), $urandom, {$urandom, $urandom});
        end
    endtask

    // The receiver stalls at random, or for a fixed stretch when a hold is requested.
    always @(negedge clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Every result transfer is compared with the oldest outstanding expectation.
    always @(posedge clk) begin : result_check
        alarm_reply_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (replies_q.size() == 0) begin
                $error("result transfer with no operation outstanding");
                errors++;
            end else begin
                want = replies_q.pop_front();
                if (status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (found_index !== want.found) begin
                    $error("found_index: expected %0d, got %0d", want.found, found_index);
                    errors++;
                end
                if (removed_count !== want.removed) begin
                    $error("removed_count: expected %0d, got %0d", want.removed, removed_count);
                    errors++;
                end
                if (entries_held !== want.held) begin
                    $error("entries_held: expected %0d, got %0d", want.held, entries_held);
                    errors++;
                end
            end
        end
    end

    // The watchdog restarts its count on any transfer on either channel.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_alarm_table_core_tb NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // First phase: a sluggish receiver.
        send_idle_pct = 27;
        recv_idle_pct = 70;
        test_directed();
        test_full_table();
        test_random(470);

        // Second phase: a sluggish sender.
        send_idle_pct = 70;
        recv_idle_pct = 27;
        test_random(470);

        // Last phase: no random idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(430);

        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_q.size() != 0) @(posedge clk);
        repeat (2 * ROWS) @(posedge clk);

        if (errors == 0) begin
            $display("sorted_alarm_table_core_tb OK");
        end else begin
            $display("sorted_alarm_table_core_tb NOT OK");
        end
        $finish;
    end

endmodule
